// ===== design/itp_pkg.sv =====
// ---------------------------------------------------------------------------
// itp_pkg: shared types and constants of the IPv6 text address parser
// Holds the token format passed from the classifier to the parse engine,
// the token kind codes and the sizing constants.
// ---------------------------------------------------------------------------
package itp_pkg;

    // Number of 16-bit pieces in an IPv6 address.
    localparam logic [3:0] MAX_PIECES = 4'd8;
    localparam int         PIECE_W    = 16;
    localparam int         ADDR_W     = 128;
    localparam int         HALF_W     = 64;

    // Default depth of the token queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Token kinds produced by the character classifier.
    localparam logic [1:0] TK_HEX   = 2'd0;
    localparam logic [1:0] TK_COLON = 2'd1;
    localparam logic [1:0] TK_BAD   = 2'd2;
    localparam logic [1:0] TK_EOL   = 2'd3;

    // One classified request as it sits in the queue.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] nibble;
    } t_tok;

endpackage

// ===== design/itp_in_if.sv =====
// ---------------------------------------------------------------------------
// itp_in_if: character channel of the IPv6 text address parser
// Carries one text byte or an end-of-line marker per request.
// ---------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_line;

    modport source (output valid, output character, output end_of_line, input ready);
    modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

// ===== design/itp_out_if.sv =====
// ---------------------------------------------------------------------------
// itp_out_if: result channel of the IPv6 text address parser
// Carries the valid flag and the two 64-bit halves of the parsed address.
// ---------------------------------------------------------------------------
interface itp_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output valid_res, output addr_high, output addr_low,
                    input ready);
    modport sink   (input valid, input valid_res, input addr_high, input addr_low,
                    output ready);
endinterface

// ===== design/itp_front.sv =====
// ---------------------------------------------------------------------------
// itp_front: input classifier
// Accepts character requests and turns each into a token: hex digit with
// its value, colon, bad character or end of line.
// ---------------------------------------------------------------------------
module itp_front (
    itp_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output itp_pkg::t_tok  o_tok
);
    import itp_pkg::*;

    logic [7:0] c;

    assign c          = i_in.character;
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Classify the byte and extract the digit value.
    always_comb begin
        o_tok.kind   = TK_BAD;
        o_tok.nibble = 4'd0;
        if (i_in.end_of_line) begin
            o_tok.kind = TK_EOL;
        end else if (c == 8'h3A) begin
            o_tok.kind = TK_COLON;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            o_tok.kind   = TK_HEX;
            o_tok.nibble = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            o_tok.kind   = TK_HEX;
            o_tok.nibble = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            o_tok.kind   = TK_HEX;
            o_tok.nibble = 4'(c - 8'h37);
        end
    end

endmodule

// ===== design/itp_queue.sv =====
// ---------------------------------------------------------------------------
// itp_queue: token queue
// Small register FIFO that decouples the classifier from the parse engine.
// ---------------------------------------------------------------------------
module itp_queue #(
    parameter int DEPTH = itp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itp_pkg::t_tok i_tok,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output itp_pkg::t_tok o_tok
);
    import itp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_tok          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/itp_back.sv =====
// ---------------------------------------------------------------------------
// itp_back: parse engine
// Applies one token per cycle to the parse state, but an end-of-line token
// waits while a result is held. On end of line it closes the last piece,
// places the pieces around the gap and loads the result register.
// ---------------------------------------------------------------------------
module itp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    input  itp_pkg::t_tok  i_tok,
    output logic           o_pop,
    itp_out_if.source      o_out
);
    import itp_pkg::*;

    // Parse state.
    logic [ADDR_W-1:0]  r_store;
    logic [3:0]         r_count;
    logic [3:0]         r_gap;
    logic               r_gap_seen;
    logic               r_colon;
    logic               r_in_piece;
    logic [PIECE_W-1:0] r_accum;
    logic               r_failed;

    logic [ADDR_W-1:0]  n_store;
    logic [3:0]         n_count;
    logic [3:0]         n_gap;
    logic               n_gap_seen;
    logic               n_colon;
    logic               n_in_piece;
    logic [PIECE_W-1:0] n_accum;
    logic               n_failed;

    // Result register.
    logic               r_out_valid;
    logic               r_res_ok;
    logic [ADDR_W-1:0]  r_res_addr;

    // Piece close and address assembly.
    logic [ADDR_W-1:0]  w_store;
    logic               w_full;
    logic [ADDR_W-1:0]  f_store;
    logic [3:0]         f_count;
    logic               f_failed;
    logic [3:0]         shift_in;
    logic [ADDR_W-1:0]  head_mask;
    logic [ADDR_W-1:0]  tail_mask;
    logic [ADDR_W-1:0]  asm_addr;
    logic               is_eol;

    // Mask over the pieces below index n; piece 0 is the top 16 bits.
    function automatic logic [ADDR_W-1:0] piece_mask(input logic [3:0] n);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int i = 0; i < int'(MAX_PIECES); i++) begin
            if (4'(i) < n) begin
                m[ADDR_W-1-PIECE_W*i -: PIECE_W] = '1;
            end
        end
        return m;
    endfunction

    assign is_eol = (i_tok.kind == TK_EOL);
    assign o_pop  = i_tok_valid && (!is_eol || !r_out_valid || o_out.ready);

    // Store with the collected piece written at the next free slot.
    always_comb begin
        w_store = r_store;
        for (int i = 0; i < int'(MAX_PIECES); i++) begin
            if (r_count[2:0] == 3'(i)) begin
                w_store[ADDR_W-1-PIECE_W*i -: PIECE_W] = r_accum;
            end
        end
        w_full = (r_count >= MAX_PIECES);
    end

    // Final close of the open piece at end of line.
    always_comb begin
        f_store  = r_store;
        f_count  = r_count;
        f_failed = r_failed;
        if (!r_failed && r_in_piece) begin
            if (w_full) begin
                f_failed = 1'b1;
            end else begin
                f_store = w_store;
                f_count = r_count + 4'd1;
            end
        end
    end

    // Pieces before the gap stay; the rest slide to the low end.
    always_comb begin
        shift_in  = MAX_PIECES - f_count;
        head_mask = r_gap_seen ? piece_mask(r_gap) : '0;
        tail_mask = piece_mask(f_count) & ~head_mask;
        asm_addr  = (f_store & head_mask)
                  | ((f_store & tail_mask) >> {shift_in, 4'b0000});
    end

    // Next parse state for one token.
    always_comb begin
        n_store    = r_store;
        n_count    = r_count;
        n_gap      = r_gap;
        n_gap_seen = r_gap_seen;
        n_colon    = r_colon;
        n_in_piece = r_in_piece;
        n_accum    = r_accum;
        n_failed   = r_failed;
        if (is_eol) begin
            n_count    = '0;
            n_gap      = '0;
            n_gap_seen = 1'b0;
            n_colon    = 1'b0;
            n_in_piece = 1'b0;
            n_accum    = '0;
            n_failed   = 1'b0;
        end else if (!r_failed) begin
            unique case (i_tok.kind)
                TK_HEX: begin
                    n_colon    = 1'b0;
                    n_in_piece = 1'b1;
                    n_accum    = {r_accum[PIECE_W-5:0], i_tok.nibble};
                end
                TK_COLON: begin
                    if (r_in_piece) begin
                        n_in_piece = 1'b0;
                        n_accum    = '0;
                        if (w_full) begin
                            n_failed = 1'b1;
                        end else begin
                            n_store = w_store;
                            n_count = r_count + 4'd1;
                        end
                    end
                    if (r_colon) begin
                        n_colon = 1'b0;
                        if (r_gap_seen) begin
                            n_failed = 1'b1;
                        end else begin
                            n_gap_seen = 1'b1;
                            n_gap      = n_count;
                        end
                    end else begin
                        n_colon = 1'b1;
                    end
                end
                TK_BAD: begin
                    n_failed = 1'b1;
                end
                default: begin
                    n_failed = r_failed;
                end
            endcase
        end
    end

    // Piece storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_store <= n_store;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_gap      <= '0;
            r_gap_seen <= 1'b0;
            r_colon    <= 1'b0;
            r_in_piece <= 1'b0;
            r_accum    <= '0;
            r_failed   <= 1'b0;
        end else if (o_pop) begin
            r_count    <= n_count;
            r_gap      <= n_gap;
            r_gap_seen <= n_gap_seen;
            r_colon    <= n_colon;
            r_in_piece <= n_in_piece;
            r_accum    <= n_accum;
            r_failed   <= n_failed;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_eol) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; a rejected line reads as address zero.
    always_ff @(posedge i_clk) begin
        if (o_pop && is_eol) begin
            r_res_ok   <= !f_failed;
            r_res_addr <= f_failed ? '0 : asm_addr;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.valid_res = r_res_ok;
    assign o_out.addr_high = r_res_addr[ADDR_W-1:HALF_W];
    assign o_out.addr_low  = r_res_addr[HALF_W-1:0];

endmodule

// ===== design/ipv6_text_address_parser.sv =====
// ---------------------------------------------------------------------------
// ipv6_text_address_parser: IPv6 address text to 128-bit binary
// Streams an address string one byte per request and returns the parsed
// address with a valid flag on each end-of-line request.
//
//   Channel  Dir  Payload                            Request
//   i_in     in   character[7:0], end_of_line        one byte or end of line
//   o_out    out  valid_res, addr_high, addr_low     one result per line
//
// Sustains one request per cycle on i_in; the parse engine applies one
// token per cycle. A result is registered: its end-of-line request is
// written into the token queue and, once popped, loads the result
// register. The token queue (QUEUE_DEPTH entries) absorbs stalls on
// o_out: only end-of-line tokens wait for the result register, so i_in
// drops ready only when the queue fills. Reset is synchronous and
// clears the queue, the parse state and the result valid flag.
// ---------------------------------------------------------------------------
module ipv6_text_address_parser #(
    parameter int QUEUE_DEPTH = itp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    logic q_full;
    logic q_push;
    t_tok q_in_tok;
    logic q_valid;
    t_tok q_out_tok;
    logic q_pop;

    // Classifier.
    itp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_tok    (q_in_tok)
    );

    // Token queue.
    itp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (q_in_tok),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_out_tok)
    );

    // Parse engine and result register.
    itp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_out_tok),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

// ===== design/itp_checker.sv =====
// ---------------------------------------------------------------------------
// itp_checker: port-level checks of the IPv6 text address parser
// Tracks end-of-line requests against delivered results and checks the
// result channel behavior.
// ---------------------------------------------------------------------------
module itp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_eol,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_valid_res,
    input logic [63:0] i_out_addr_high,
    input logic [63:0] i_out_addr_low
);
    logic [7:0] r_pending;
    logic       eol_acc;
    logic       res_acc;

    assign eol_acc = i_in_valid && i_in_ready && i_in_eol;
    assign res_acc = i_out_valid && i_out_ready;

    // Lines accepted but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (eol_acc && !res_acc) begin
            r_pending <= r_pending + 8'd1;
        end else if (res_acc && !eol_acc) begin
            r_pending <= r_pending - 8'd1;
        end
    end

    // A result is only shown for a line that is still owed.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 8'd0))
        else $error("result shown with no open line");

    // A rejected line carries address zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_valid_res) |-> (i_out_addr_high == 64'd0 &&
                                               i_out_addr_low == 64'd0))
        else $error("rejected line with nonzero address");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_valid_res)
            && $stable(i_out_addr_high) && $stable(i_out_addr_low)))
        else $error("stalled result changed");

endmodule

bind ipv6_text_address_parser itp_checker u_itp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_eol        (i_in.end_of_line),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_valid_res (o_out.valid_res),
    .i_out_addr_high (o_out.addr_high),
    .i_out_addr_low  (o_out.addr_low)
);

// ===== test/itp_tb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itp_tb_pkg: address predictor and result checker for the parser bench
// Follows the parse of each address string request by request. Every
// end-of-line request queues the address that the parser should return, and
// each result taken from the block is compared with the oldest entry.
// ---------------------------------------------------------------------------
package itp_tb_pkg;

    // Characters that the parser treats specially.
    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_F    = 8'h66;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_F    = 8'h46;

    // Number of pieces in a full address.
    localparam int PIECES = int'(itp_pkg::MAX_PIECES);

    // One predicted result of an end-of-line request.
    typedef struct {
        logic        ok;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_result;

    class addr_parse_scoreboard;
        // Parse state of the string in progress.
        logic [15:0] pieces [PIECES];
        int          piece_cnt;
        int          gap_at;
        bit          gap_open;
        bit          colon_half;
        bit          digits_open;
        logic [15:0] digit_acc;
        bit          rejected;

        // Addresses still owed by the block, oldest first.
        t_addr_result expected_addrs [$];

        int errors;
        int checked;
        int good_lines;
        int bad_lines;

        function new();
            errors     = 0;
            checked    = 0;
            good_lines = 0;
            bad_lines  = 0;
            start_line();
        endfunction

        // Clear the parse state for the next string.
        function void start_line();
            foreach (pieces[i]) pieces[i] = '0;
            piece_cnt   = 0;
            gap_at      = 0;
            gap_open    = 0;
            colon_half  = 0;
            digits_open = 0;
            digit_acc   = '0;
            rejected    = 0;
        endfunction

        // Value of a hex digit, or -1 for any other byte.
        function int nibble_of(logic [7:0] c);
            if (c >= DIGIT_0 && c <= DIGIT_9) return int'(c - DIGIT_0);
            if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
            if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
            return -1;
        endfunction

        // Store the digit run being collected; a ninth piece rejects the string.
        function void close_piece();
            if (!digits_open) return;
            digits_open = 0;
            if (piece_cnt >= PIECES) begin
                rejected = 1;
            end else begin
                pieces[piece_cnt] = digit_acc;
                piece_cnt++;
            end
            digit_acc = '0;
        endfunction

        // Place the stored pieces, with the zero run at the gap or at the front.
        function t_addr_result assemble();
            t_addr_result res;
            logic [127:0] addr;
            int           pos;
            int           i;
            addr = '0;
            if (!rejected) begin
                for (i = 0; i < piece_cnt; i++) begin
                    pos = (gap_open && i < gap_at) ? i : i + (PIECES - piece_cnt);
                    addr[16 * (7 - pos) +: 16] = pieces[i];
                end
            end
            res.ok        = !rejected;
            res.addr_high = addr[127:64];
            res.addr_low  = addr[63:0];
            return res;
        endfunction

        // Apply one accepted request to the predicted parse.
        function void note_request(logic [7:0] c, logic eol);
            int v;
            if (eol) begin
                if (!rejected) close_piece();
                expected_addrs.insert(expected_addrs.size(), assemble());
                start_line();
                return;
            end
            // Once rejected, everything up to end of line is ignored.
            if (rejected) return;
            if (c == COLON_CHAR) begin
                close_piece();
                if (colon_half) begin
                    colon_half = 0;
                    if (gap_open) begin
                        rejected = 1;
                    end else begin
                        gap_open = 1;
                        gap_at   = piece_cnt;
                    end
                end else begin
                    colon_half = 1;
                end
                return;
            end
            v = nibble_of(c);
            if (v < 0) begin
                rejected = 1;
                return;
            end
            colon_half  = 0;
            digits_open = 1;
            digit_acc   = {digit_acc[11:0], 4'(v)};
        endfunction

        function int pending();
            return expected_addrs.size();
        endfunction

        // Print one mismatch line and count it.
        task report(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        // Compare one accepted result with the oldest predicted address.
        task check_result(logic vr, logic [63:0] hi, logic [63:0] lo);
            t_addr_result want;
            if (expected_addrs.size() == 0) begin
                report($sformatf("result with nothing owed: valid_res=%0b %h_%h", vr, hi, lo));
                return;
            end
            want = expected_addrs.pop_front();
            checked++;
            if (want.ok) good_lines++;
            else bad_lines++;
            if (vr !== want.ok)
                report($sformatf("line %0d valid_res %0b, want %0b", checked, vr, want.ok));
            if (hi !== want.addr_high)
                report($sformatf("line %0d addr_high %h, want %h", checked, hi, want.addr_high));
            if (lo !== want.addr_low)
                report($sformatf("line %0d addr_low %h, want %h", checked, lo, want.addr_low));
        endtask
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: bench for the IPv6 text address parser
// Streams short directed strings and then random address lines, mostly
// well-formed with random digits, gaps and letter case, the rest with too
// many pieces, stray bytes, extra gaps or pure noise. Both channels stall in
// random bursts, and every result is checked against a predicted address.
// ---------------------------------------------------------------------------
module tb_top;
    import itp_tb_pkg::*;

    localparam int RANDOM_REQS = 750;
    localparam int CALM_AFTER  = 640;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  in_if ();
    itp_out_if out_if ();

    ipv6_text_address_parser dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    addr_parse_scoreboard sb;

    logic [7:0] line_buf [$];
    int         reqs_sent;
    int         lines_sent;
    int         cycles;
    int         src_odds;
    bit         calm;

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("ipv6_text_address_parser: mismatch");
            $finish;
        end
    end

    // Present one request and wait until the parser takes it.
    task automatic send_req(input logic [7:0] ch, input logic eol);
        int idle;
        if (!calm && src_odds != 0 && $urandom_range(1, src_odds * 3) == 1) begin
            idle = $urandom_range(1, 11);
            in_if.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.character   <= ch;
        in_if.end_of_line <= eol;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_request(ch, eol);
        reqs_sent++;
    endtask

    // Send the buffered line followed by end of line with a random byte.
    task automatic send_line();
        foreach (line_buf[i]) send_req(line_buf[i], 1'b0);
        send_req(8'($urandom_range(0, 255)), 1'b1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        line_buf.delete();
        for (i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
        send_line();
    endtask

    // Random hex digit in either letter case.
    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return DIGIT_0 + 8'(v);
        if ($urandom_range(0, 1) == 1) return UPPER_A + 8'(v - 10);
        return LOWER_A + 8'(v - 10);
    endfunction

    // Build n pieces with a "::" before piece gap_at (no gap when negative).
    function automatic void build_address(input int n, input int gap_at, input bit long_ok);
        int i;
        int nd;
        line_buf.delete();
        if (gap_at == 0) begin
            line_buf.insert(line_buf.size(), COLON_CHAR);
            line_buf.insert(line_buf.size(), COLON_CHAR);
        end
        for (i = 0; i < n; i++) begin
            if (i > 0) begin
                line_buf.insert(line_buf.size(), COLON_CHAR);
                if (gap_at == i) line_buf.insert(line_buf.size(), COLON_CHAR);
            end
            nd = (long_ok && $urandom_range(0, 7) == 0) ? $urandom_range(5, 6)
                                                        : $urandom_range(1, 4);
            repeat (nd) line_buf.insert(line_buf.size(), hex_char());
        end
        if (n > 0 && gap_at == n) begin
            line_buf.insert(line_buf.size(), COLON_CHAR);
            line_buf.insert(line_buf.size(), COLON_CHAR);
        end
    endfunction

    // Result side: check taken results and stall in random bursts.
    initial begin : result_sink
        int hold;
        int odds;
        hold = 0;
        odds = 2;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_result(out_if.valid_res, out_if.addr_high, out_if.addr_low);
            if (cycles % 64 == 0) odds = $urandom_range(0, 4);
            if (i_rst_n !== 1'b1) begin
                out_if.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (!calm && odds != 0 && $urandom_range(1, odds * 3) == 1) begin
                hold = $urandom_range(1, 11) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin : stimulus
        int kind;
        int n;
        int g;
        int idx;
        sb          = new();
        reqs_sent   = 0;
        lines_sent  = 0;
        src_odds    = 2;
        calm        = 0;
        i_rst_n     = 1'b0;
        in_if.valid       = 1'b0;
        in_if.character   = '0;
        in_if.end_of_line = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty string, "::" then a lone colon, a second gap,
        // a long digit run with too few pieces, and bad bytes at both extremes.
        send_text("");
        send_text(":::");
        send_text("::1::");
        send_text("12345:a");
        line_buf = '{UPPER_F, 8'hFF, COLON_CHAR};
        send_line();
        line_buf = '{8'h00};
        send_line();

        // Random lines.
        while (reqs_sent < RANDOM_REQS) begin
            if (lines_sent % 6 == 0) src_odds = $urandom_range(0, 4);
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                // Well-formed, with or without a gap.
                n = $urandom_range(0, 8);
                g = ($urandom_range(0, 1) == 1) ? $urandom_range(0, n) : -1;
                build_address(n, g, 1'b1);
            end else if (kind < 14) begin
                // Too many pieces.
                build_address($urandom_range(9, 10), -1, 1'b0);
            end else if (kind < 16) begin
                // One byte replaced by anything.
                build_address($urandom_range(1, 8), -1, 1'b1);
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (kind < 18) begin
                // Extra colons: a second gap or a colon run.
                n = $urandom_range(2, 6);
                build_address(n, $urandom_range(0, n), 1'b1);
                idx = $urandom_range(0, line_buf.size());
                line_buf.insert(idx, COLON_CHAR);
                if ($urandom_range(0, 1) == 1) line_buf.insert(idx, COLON_CHAR);
            end else begin
                // Noise: any bytes, colons and digits mixed.
                line_buf.delete();
                repeat ($urandom_range(0, 12)) begin
                    case ($urandom_range(0, 3))
                        0: line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
                        1: line_buf.insert(line_buf.size(), COLON_CHAR);
                        default: line_buf.insert(line_buf.size(), hex_char());
                    endcase
                end
            end
            if (reqs_sent >= CALM_AFTER) calm = 1;
            send_line();
        end
        in_if.valid <= 1'b0;

        // Drain.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Streamed %0d requests in %0d address lines.", reqs_sent, lines_sent);
        $display("Checked %0d results: %0d accepted and %0d rejected strings.",
                 sb.checked, sb.good_lines, sb.bad_lines);
        if (sb.errors == 0)
            $display("ipv6_text_address_parser: match");
        else
            $display("ipv6_text_address_parser: mismatch");
        $finish;
    end

endmodule
